@@ hw/rtl/mcpid_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpid_pkg: shared types and constants for the multi-channel PID controller
// Word formats of both streams, register indexes, sequencer states and
// the fixed-point constants of the drive output.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpid_pkg;

    // Defaults of the top-level parameters
    localparam int CHANNELS_DEF       = 4;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = SAMPLE_W + 1;    // target - actual
    localparam int DELTA_W    = ERR_W + 1;       // e - previous e
    localparam int INTEG_W    = 25;              // per-channel integral
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 23;
    localparam int DEADBAND_W = 16;
    localparam int SENS_W     = 16;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Multiplier operand and accumulator widths
    localparam int MUL_A_W = INTEG_W;
    localparam int ACC_W   = MUL_A_W + GAIN_W;   // one product, sum of three fits

    // Drive output, Q2.14
    localparam int          DRIVE_W    = 16;
    localparam int          DRIVE_FRAC = 14;
    localparam logic [15:0] DRIVE_ZERO = 16'd0;
    localparam logic [15:0] DRIVE_ONE  = 16'd16384;
    localparam logic [15:0] DRIVE_TWO  = 16'd32768;

    // Dividend: |sum of terms| scaled by the output fraction
    localparam int NUM_W = ACC_W + DRIVE_FRAC;

    // Multiplier passes: P, I, D
    localparam int MUL_STEPS = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_INT_LIMIT = 3'd3,
        REG_DEADBAND  = 3'd4,
        REG_SENS      = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DONE
    } pid_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target;
        logic signed [SAMPLE_W-1:0] actual;
        logic        [CHAN_W-1:0]   channel;
    } pid_in_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [CHAN_W-1:0]  channel_out;
    } pid_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/multi_channel_pid_controller.sv @@
// ----------------------------------------------------------------------------
// multi_channel_pid_controller: per-channel PID with deadband and anti-windup
// One shared 25x16 multiplier and a restoring divider under a small
// sequencer compute the Q2.14 drive for one word at a time.
// ----------------------------------------------------------------------------
// One word is taken in the idle state and worked on in the states ST_PREP
// (error and integral update), ST_MUL (the three passes of the shared
// multiplier), ST_DIV_SETUP (divider setup), ST_DIV (the one-bit-per-cycle
// restoring divider) and ST_DONE (saturate), which waits while the last
// result has not been taken; the block takes no new word until it is back
// in the idle state. A finished result waits in the output register
// while the next word is already being worked on. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
`default_nettype none

module multi_channel_pid_controller #(
    parameter int CHANNELS       = mcpid_pkg::CHANNELS_DEF,
    parameter int GAIN_FRAC_BITS = mcpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input words
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire mcpid_pkg::pid_in_t                  s_data,
    // result words
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output mcpid_pkg::pid_out_t                      m_data,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mcpid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import mcpid_pkg::*;

    localparam int IDXW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEN_W = SENS_W + GAIN_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int CH_CMP = (CHANNELS > 7) ? 7 : CHANNELS;

    // Control
    pid_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    // Configuration
    logic signed [GAIN_W-1:0]     gain_p_reg, gain_p_next;
    logic signed [GAIN_W-1:0]     gain_i_reg, gain_i_next;
    logic signed [GAIN_W-1:0]     gain_d_reg, gain_d_next;
    logic        [LIMIT_W-1:0]    limit_reg, limit_next;
    logic        [DEADBAND_W-1:0] deadband_reg, deadband_next;
    logic        [SENS_W-1:0]     sens_reg, sens_next;

    // Per-channel state
    logic signed [INTEG_W-1:0] integ_reg [CHANNELS];
    logic signed [INTEG_W-1:0] integ_next [CHANNELS];
    logic signed [ERR_W-1:0]   prev_reg [CHANNELS];
    logic signed [ERR_W-1:0]   prev_next [CHANNELS];

    // Datapath
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic        [IDXW-1:0]    idx_reg, idx_next;
    logic        [CHAN_W-1:0]  chan_reg, chan_next;
    logic signed [INTEG_W-1:0] sum_reg, sum_next;
    logic signed [DELTA_W-1:0] dlt_reg, dlt_next;
    logic                      ki_reg, ki_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   prod_reg, prod_next;
    logic                      neg_reg, neg_next;
    logic        [NUM_W-1:0]   num_reg, num_next;
    logic        [DEN_W-1:0]   rem_reg, rem_next;
    logic        [DEN_W-1:0]   den_reg, den_next;
    pid_out_t                  out_reg, out_next;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [GAIN_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]   mul_p;

    assign mul_p = mul_a * mul_b;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // Next-state and datapath logic
    always_comb begin
        logic [2:0]                chan_v;
        logic signed [INTEG_W-1:0] sum_raw;
        logic signed [INTEG_W-1:0] lim_pos;
        logic        [ERR_W-1:0]   err_mag;
        logic        [ACC_W-1:0]   acc_mag;
        logic        [DEN_W:0]     rem_sh;
        logic                      qbit;
        logic                      q_big;
        logic        [DRIVE_FRAC:0] q_low;
        logic        [SENS_W-1:0]  sens_eff;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        gain_p_next   = gain_p_reg;
        gain_i_next   = gain_i_reg;
        gain_d_next   = gain_d_reg;
        limit_next    = limit_reg;
        deadband_next = deadband_reg;
        sens_next     = sens_reg;
        integ_next    = integ_reg;
        prev_next     = prev_reg;
        err_next      = err_reg;
        idx_next      = idx_reg;
        chan_next     = chan_reg;
        sum_next      = sum_reg;
        dlt_next      = dlt_reg;
        ki_next       = ki_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        out_next      = out_reg;
        mul_a         = '0;
        mul_b         = '0;
        chan_v        = '0;
        sum_raw       = '0;
        lim_pos       = $signed({{(INTEG_W-LIMIT_W){1'b0}}, limit_reg});
        err_mag       = '0;
        acc_mag       = '0;
        rem_sh        = '0;
        qbit          = 1'b0;
        q_big         = 1'b0;
        q_low         = '0;
        sens_eff      = (sens_reg == '0) ? SENS_W'(1) : sens_reg;

        // register writes
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:    gain_p_next   = $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:    gain_i_next   = $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:    gain_d_next   = $signed(cfg_data[GAIN_W-1:0]);
                REG_INT_LIMIT: limit_next    = cfg_data[LIMIT_W-1:0];
                REG_DEADBAND:  deadband_next = cfg_data[DEADBAND_W-1:0];
                REG_SENS:      sens_next     = cfg_data[SENS_W-1:0];
                default: ;
            endcase
        end

        // result word taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next = $signed({s_data.target[SAMPLE_W-1], s_data.target})
                             - $signed({s_data.actual[SAMPLE_W-1], s_data.actual});
                    chan_next = s_data.channel;
                    // channel modulo CHANNELS, at most three subtractions
                    chan_v = {1'b0, s_data.channel};
                    for (int k = 0; k < 3; k++) begin
                        if (chan_v >= 3'(CH_CMP)) begin
                            chan_v = chan_v - 3'(CH_CMP);
                        end
                    end
                    idx_next   = IDXW'(chan_v);
                    state_next = ST_PREP;
                end
            end

            // integral update with deadband and clamp, derivative delta
            ST_PREP: begin
                sum_raw = integ_reg[idx_reg]
                        + $signed({{(INTEG_W-ERR_W){err_reg[ERR_W-1]}}, err_reg});
                err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : err_reg;
                if (err_mag <= {1'b0, deadband_reg}) begin
                    sum_next = '0;
                    ki_next  = 1'b0;
                end else begin
                    ki_next = 1'b1;
                    if (sum_raw >= lim_pos) begin
                        sum_next = lim_pos;
                    end else if (sum_raw <= -lim_pos) begin
                        sum_next = -lim_pos;
                    end else begin
                        sum_next = sum_raw;
                    end
                end
                dlt_next = $signed({err_reg[ERR_W-1], err_reg})
                         - $signed({prev_reg[idx_reg][ERR_W-1], prev_reg[idx_reg]});
                integ_next[idx_reg] = sum_next;
                prev_next[idx_reg]  = err_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end

            // products registered, accumulated in the following cycle
            ST_MUL: begin
                case (cnt_reg)
                    CNT_W'(0): begin
                        mul_a = $signed({{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg});
                        mul_b = gain_p_reg;
                    end
                    CNT_W'(1): begin
                        mul_a = sum_reg;
                        mul_b = ki_reg ? gain_i_reg : '0;
                    end
                    CNT_W'(2): begin
                        mul_a = $signed({{(MUL_A_W-DELTA_W){dlt_reg[DELTA_W-1]}}, dlt_reg});
                        mul_b = gain_d_reg;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                prod_next = mul_p;
                if (cnt_reg != '0) begin
                    acc_next = acc_reg + prod_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS)) begin
                    state_next = ST_DIV_SETUP;
                end
            end

            // magnitude of the sum, divisor = sensitivity << frac bits
            ST_DIV_SETUP: begin
                neg_next   = acc_reg[ACC_W-1];
                acc_mag    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                num_next   = {acc_mag, {DRIVE_FRAC{1'b0}}};
                rem_next   = '0;
                den_next   = DEN_W'(sens_eff) << GAIN_FRAC_BITS;
                cnt_next   = CNT_W'(NUM_W);
                state_next = ST_DIV;
            end

            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                rem_sh = {rem_reg, num_reg[NUM_W-1]};
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_sh = rem_sh - {1'b0, den_reg};
                    qbit   = 1'b1;
                end
                rem_next = rem_sh[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], qbit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end

            // floor, offset by 1.0, saturate to 0..2.0
            ST_DONE: begin
                q_big = |num_reg[NUM_W-1:DRIVE_FRAC];
                if (!m_valid_reg || m_ready) begin
                    if (!neg_reg) begin
                        out_next.drive = q_big ? DRIVE_TWO
                                       : DRIVE_ONE + DRIVE_W'(num_reg[DRIVE_FRAC-1:0]);
                    end else begin
                        q_low = {1'b0, num_reg[DRIVE_FRAC-1:0]}
                              + (DRIVE_FRAC+1)'(rem_reg != '0);
                        if (q_big || q_low[DRIVE_FRAC]) begin
                            out_next.drive = DRIVE_ZERO;
                        end else begin
                            out_next.drive = DRIVE_ONE - DRIVE_W'(q_low);
                        end
                    end
                    out_next.channel_out = chan_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control, configuration and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            limit_reg    <= '0;
            deadband_reg <= '0;
            sens_reg     <= SENS_W'(1);
            for (int k = 0; k < CHANNELS; k++) begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end else begin
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            gain_p_reg   <= gain_p_next;
            gain_i_reg   <= gain_i_next;
            gain_d_reg   <= gain_d_next;
            limit_reg    <= limit_next;
            deadband_reg <= deadband_next;
            sens_reg     <= sens_next;
            integ_reg    <= integ_next;
            prev_reg     <= prev_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        err_reg  <= err_next;
        idx_reg  <= idx_next;
        chan_reg <= chan_next;
        sum_reg  <= sum_next;
        dlt_reg  <= dlt_next;
        ki_reg   <= ki_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
